// ===== rtl/rmth_pkg.sv =====
package rmth_pkg;

  localparam int CAPACITY   = 1024;
  localparam int HEAP_DEPTH = CAPACITY / 2 + 1;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int SUM_W      = CNT_W + 2;
  localparam int KEY_W      = 32;
  localparam logic [KEY_W-1:0] SIGN_BIT = {1'b1, {(KEY_W-1){1'b0}}};

  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_ADD     = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_PUSH,
    OP_POP,
    OP_REPLACE
  } heap_op_t;

  typedef struct packed {
    logic             valid;
    heap_op_t         op;
    logic [KEY_W-1:0] key;
  } heap_cmd_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
    logic [KEY_W-1:0] top;
  } heap_stat_t;

  typedef enum logic [2:0] {
    H_IDLE,
    H_UP,
    H_UP_W,
    H_POP_W,
    H_DN,
    H_DN_L,
    H_DN_R,
    H_DN_C
  } heap_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RST_PUSH,
    S_FIN_WAIT,
    S_PUSH,
    S_BAL,
    S_MOVE,
    S_CHK,
    S_SWAP_W,
    S_NEXT,
    S_OUT
  } top_state_t;

  // Keys carry a flipped sign bit, so unsigned order is signed order.
  function automatic logic above(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b,
                                 input logic is_max);
    above = is_max ? (a > b) : (a < b);
  endfunction

endpackage

// ===== rtl/rmth_heap.sv =====
module rmth_heap (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                is_max,
  input  rmth_pkg::heap_cmd_t cmd,
  output rmth_pkg::heap_stat_t stat
);

  localparam int LW = rmth_pkg::ADDR_W + 1;

  logic [rmth_pkg::KEY_W-1:0] mem [rmth_pkg::HEAP_DEPTH];
  logic [rmth_pkg::KEY_W-1:0] rdata_r;

  rmth_pkg::heap_state_t state_r, state_nxt;
  logic [rmth_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, n_r, n_nxt;
  logic [rmth_pkg::ADDR_W-1:0] i_r, i_nxt, bidx_r, bidx_nxt;
  logic [rmth_pkg::KEY_W-1:0]  key_r, key_nxt, bv_r, bv_nxt, top_r, top_nxt;

  logic                        we;
  logic [rmth_pkg::ADDR_W-1:0] waddr, raddr, par;
  logic [rmth_pkg::KEY_W-1:0]  wdata;
  logic [LW-1:0]               l_idx, r_idx, n_ext;
  logic [rmth_pkg::CNT_W-1:0]  cnt_dec;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmth_pkg::H_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    n_r    <= n_nxt;
    i_r    <= i_nxt;
    bidx_r <= bidx_nxt;
    key_r  <= key_nxt;
    bv_r   <= bv_nxt;
    top_r  <= top_nxt;
  end

  assign par     = (i_r - rmth_pkg::ADDR_W'(1)) >> 1;
  assign l_idx   = {i_r, 1'b1};
  assign r_idx   = l_idx + LW'(1);
  assign n_ext   = LW'(n_r);
  assign cnt_dec = cnt_r - rmth_pkg::CNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    bidx_nxt  = bidx_r;
    key_nxt   = key_r;
    bv_nxt    = bv_r;
    we        = 1'b0;
    waddr     = i_r;
    wdata     = key_r;
    raddr     = '0;
    case (state_r)
      rmth_pkg::H_IDLE: begin
        if (cmd.valid) begin
          case (cmd.op)
            rmth_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
            end
            rmth_pkg::OP_PUSH: begin
              i_nxt     = cnt_r[rmth_pkg::ADDR_W-1:0];
              key_nxt   = cmd.key;
              cnt_nxt   = cnt_r + rmth_pkg::CNT_W'(1);
              state_nxt = rmth_pkg::H_UP;
            end
            rmth_pkg::OP_POP: begin
              cnt_nxt = cnt_dec;
              n_nxt   = cnt_dec;
              i_nxt   = '0;
              raddr   = cnt_dec[rmth_pkg::ADDR_W-1:0];
              if (cnt_dec != '0) begin
                state_nxt = rmth_pkg::H_POP_W;
              end
            end
            default: begin
              key_nxt   = cmd.key;
              i_nxt     = '0;
              n_nxt     = cnt_r;
              state_nxt = rmth_pkg::H_DN;
            end
          endcase
        end
      end
      rmth_pkg::H_UP: begin
        if (i_r == '0) begin
          we        = 1'b1;
          state_nxt = rmth_pkg::H_IDLE;
        end else begin
          raddr     = par;
          state_nxt = rmth_pkg::H_UP_W;
        end
      end
      rmth_pkg::H_UP_W: begin
        we = 1'b1;
        if (rmth_pkg::above(key_r, rdata_r, is_max)) begin
          wdata     = rdata_r;
          i_nxt     = par;
          state_nxt = rmth_pkg::H_UP;
        end else begin
          state_nxt = rmth_pkg::H_IDLE;
        end
      end
      rmth_pkg::H_POP_W: begin
        key_nxt   = rdata_r;
        state_nxt = rmth_pkg::H_DN;
      end
      rmth_pkg::H_DN: begin
        if (l_idx >= n_ext) begin
          we        = 1'b1;
          state_nxt = rmth_pkg::H_IDLE;
        end else begin
          raddr     = l_idx[rmth_pkg::ADDR_W-1:0];
          state_nxt = rmth_pkg::H_DN_L;
        end
      end
      rmth_pkg::H_DN_L: begin
        bv_nxt   = rdata_r;
        bidx_nxt = l_idx[rmth_pkg::ADDR_W-1:0];
        if (r_idx < n_ext) begin
          raddr     = r_idx[rmth_pkg::ADDR_W-1:0];
          state_nxt = rmth_pkg::H_DN_R;
        end else begin
          state_nxt = rmth_pkg::H_DN_C;
        end
      end
      rmth_pkg::H_DN_R: begin
        // On a tie the left child wins.
        if (rmth_pkg::above(rdata_r, bv_r, is_max)) begin
          bv_nxt   = rdata_r;
          bidx_nxt = r_idx[rmth_pkg::ADDR_W-1:0];
        end
        state_nxt = rmth_pkg::H_DN_C;
      end
      rmth_pkg::H_DN_C: begin
        we = 1'b1;
        if (rmth_pkg::above(bv_r, key_r, is_max)) begin
          wdata     = bv_r;
          i_nxt     = bidx_r;
          state_nxt = rmth_pkg::H_DN;
        end else begin
          state_nxt = rmth_pkg::H_IDLE;
        end
      end
      default: begin
        state_nxt = rmth_pkg::H_IDLE;
      end
    endcase
  end

  // The root is mirrored in a register so the tops are always at hand.
  assign top_nxt = (we && waddr == '0) ? wdata : top_r;

  assign stat.idle  = (state_r == rmth_pkg::H_IDLE);
  assign stat.count = cnt_r;
  assign stat.top   = top_r;

endmodule

// ===== rtl/running_median_two_heaps_core.sv =====
// A full store is answered with out_status set and leaves both heaps untouched.
// Throughput: one word at a time; busy stays high until the result is produced,
// set by the single read and write port of each heap memory used by its sift unit.
// The receiver cannot stall: out_valid lasts one cycle.
// Reset (rst_n low, synchronous) empties both heaps; heap memories are not cleared.
module running_median_two_heaps_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic signed [31:0] in_value_a,
  input  logic signed [31:0] in_value_b,
  output logic               out_valid,
  output logic signed [31:0] out_median,
  output logic               out_status
);

  rmth_pkg::top_state_t state_r, state_nxt;
  rmth_pkg::heap_cmd_t  lo_cmd, up_cmd;
  rmth_pkg::heap_stat_t lo_stat, up_stat;

  logic [rmth_pkg::KEY_W-1:0] key_r, key_nxt, b_r, b_nxt, mv_r, mv_nxt;
  logic [rmth_pkg::KEY_W-1:0] median_r, median_nxt;
  logic second_r, second_nxt, status_r, status_nxt, valid_r, valid_nxt;
  logic full, too_big, swap;

  rmth_heap u_lower (
    .clk    (clk),
    .rst_n  (rst_n),
    .is_max (1'b1),
    .cmd    (lo_cmd),
    .stat   (lo_stat)
  );

  rmth_heap u_upper (
    .clk    (clk),
    .rst_n  (rst_n),
    .is_max (1'b0),
    .cmd    (up_cmd),
    .stat   (up_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmth_pkg::S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    key_r    <= key_nxt;
    b_r      <= b_nxt;
    mv_r     <= mv_nxt;
    second_r <= second_nxt;
    status_r <= status_nxt;
    median_r <= median_nxt;
  end

  assign full = (rmth_pkg::SUM_W'(lo_stat.count) + rmth_pkg::SUM_W'(up_stat.count)
                 + rmth_pkg::SUM_W'(2)) > rmth_pkg::SUM_W'(rmth_pkg::CAPACITY);
  assign too_big = (rmth_pkg::SUM_W'(lo_stat.count) >
                    rmth_pkg::SUM_W'(up_stat.count) + rmth_pkg::SUM_W'(1));
  assign swap = (lo_stat.count != '0) && (up_stat.count != '0) &&
                (lo_stat.top > up_stat.top);

  always_comb begin
    state_nxt  = state_r;
    key_nxt    = key_r;
    b_nxt      = b_r;
    mv_nxt     = mv_r;
    second_nxt = second_r;
    status_nxt = status_r;
    median_nxt = median_r;
    valid_nxt  = 1'b0;
    lo_cmd     = '{valid: 1'b0, op: rmth_pkg::OP_PUSH, key: key_r};
    up_cmd     = '{valid: 1'b0, op: rmth_pkg::OP_PUSH, key: mv_r};
    case (state_r)
      rmth_pkg::S_IDLE: begin
        if (start) begin
          key_nxt    = in_value_a ^ rmth_pkg::SIGN_BIT;
          b_nxt      = in_value_b ^ rmth_pkg::SIGN_BIT;
          second_nxt = 1'b0;
          status_nxt = 1'b0;
          if (in_req_type == rmth_pkg::REQ_RESTART) begin
            lo_cmd.valid = 1'b1;
            lo_cmd.op    = rmth_pkg::OP_CLEAR;
            up_cmd.valid = 1'b1;
            up_cmd.op    = rmth_pkg::OP_CLEAR;
            state_nxt    = rmth_pkg::S_RST_PUSH;
          end else if (full) begin
            status_nxt = 1'b1;
            state_nxt  = rmth_pkg::S_OUT;
          end else begin
            state_nxt = rmth_pkg::S_PUSH;
          end
        end
      end
      rmth_pkg::S_RST_PUSH: begin
        lo_cmd.valid = 1'b1;
        state_nxt    = rmth_pkg::S_FIN_WAIT;
      end
      rmth_pkg::S_FIN_WAIT: begin
        if (lo_stat.idle) begin
          state_nxt = rmth_pkg::S_OUT;
        end
      end
      rmth_pkg::S_PUSH: begin
        lo_cmd.valid = 1'b1;
        state_nxt    = rmth_pkg::S_BAL;
      end
      rmth_pkg::S_BAL: begin
        if (lo_stat.idle) begin
          if (too_big) begin
            mv_nxt       = lo_stat.top;
            lo_cmd.valid = 1'b1;
            lo_cmd.op    = rmth_pkg::OP_POP;
            state_nxt    = rmth_pkg::S_MOVE;
          end else begin
            state_nxt = rmth_pkg::S_CHK;
          end
        end
      end
      rmth_pkg::S_MOVE: begin
        if (lo_stat.idle) begin
          up_cmd.valid = 1'b1;
          state_nxt    = rmth_pkg::S_CHK;
        end
      end
      rmth_pkg::S_CHK: begin
        if (lo_stat.idle && up_stat.idle) begin
          if (swap) begin
            // The two heaps sift down their new roots side by side.
            lo_cmd = '{valid: 1'b1, op: rmth_pkg::OP_REPLACE, key: up_stat.top};
            up_cmd = '{valid: 1'b1, op: rmth_pkg::OP_REPLACE, key: lo_stat.top};
            state_nxt = rmth_pkg::S_SWAP_W;
          end else begin
            state_nxt = rmth_pkg::S_NEXT;
          end
        end
      end
      rmth_pkg::S_SWAP_W: begin
        if (lo_stat.idle && up_stat.idle) begin
          state_nxt = rmth_pkg::S_NEXT;
        end
      end
      rmth_pkg::S_NEXT: begin
        if (!second_r) begin
          key_nxt    = b_r;
          second_nxt = 1'b1;
          state_nxt  = rmth_pkg::S_PUSH;
        end else begin
          state_nxt = rmth_pkg::S_OUT;
        end
      end
      rmth_pkg::S_OUT: begin
        valid_nxt  = 1'b1;
        median_nxt = (lo_stat.count != '0) ? (lo_stat.top ^ rmth_pkg::SIGN_BIT) : '0;
        state_nxt  = rmth_pkg::S_IDLE;
      end
      default: begin
        state_nxt = rmth_pkg::S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != rmth_pkg::S_IDLE);
  assign out_valid  = valid_r;
  assign out_median = median_r;
  assign out_status = status_r;

  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word shown while the block is busy");

  a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start the sequencer");

  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !too_big)
    else $error("lower half holds more than one extra element");

endmodule

// ===== tb/running_median_two_heaps_core_tb.sv =====
`timescale 1ns / 100ps

module running_median_two_heaps_core_tb;

  typedef struct {
    logic               req_type;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
  } median_req_t;

  typedef struct {
    logic signed [31:0] median;
    logic               status;
  } median_res_t;

  localparam int N_RANDOM    = 1200;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int QUIET_TAIL  = 250;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_req_type;
  logic signed [31:0] in_value_a;
  logic signed [31:0] in_value_b;
  logic               out_valid;
  logic signed [31:0] out_median;
  logic               out_status;

  median_req_t pending_reqs[$];
  median_res_t expected_medians[$];
  median_req_t driven_req;
  int          n_errors = 0;
  int          n_cycles = 0;
  int          gap_left = 0;

  // Predictor state: keys held with the sign bit flipped, as in the block.
  logic [31:0] lo_heap[rmth_pkg::HEAP_DEPTH];
  logic [31:0] hi_heap[rmth_pkg::HEAP_DEPTH];
  int          lo_n = 0;
  int          hi_n = 0;

  running_median_two_heaps_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req_type(in_req_type),
    .in_value_a (in_value_a),
    .in_value_b (in_value_b),
    .out_valid  (out_valid),
    .out_median (out_median),
    .out_status (out_status)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic bit ranks_higher(logic [31:0] a, logic [31:0] b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  task automatic heap_sift_down(ref logic [31:0] h[rmth_pkg::HEAP_DEPTH], input int n,
                                input bit is_max);
    int i;
    int l;
    int best;
    logic [31:0] t;
    i = 0;
    forever begin
      l = 2 * i + 1;
      best = i;
      if (l < n && ranks_higher(h[l], h[best], is_max)) best = l;
      if (l + 1 < n && ranks_higher(h[l + 1], h[best], is_max)) best = l + 1;
      if (best == i) break;
      t = h[i];
      h[i] = h[best];
      h[best] = t;
      i = best;
    end
  endtask

  task automatic heap_push(ref logic [31:0] h[rmth_pkg::HEAP_DEPTH], ref int n,
                           input logic [31:0] key, input bit is_max);
    int i;
    int par;
    logic [31:0] t;
    i = n;
    if (i >= rmth_pkg::HEAP_DEPTH) return;
    h[i] = key;
    n = i + 1;
    while (i > 0) begin
      par = (i - 1) / 2;
      if (!ranks_higher(h[i], h[par], is_max)) break;
      t = h[i];
      h[i] = h[par];
      h[par] = t;
      i = par;
    end
  endtask

  task automatic insert_key(logic [31:0] key);
    logic [31:0] y;
    logic [31:0] z;
    heap_push(lo_heap, lo_n, key, 1'b1);
    if (lo_n > hi_n + 1) begin
      y = lo_heap[0];
      lo_n--;
      lo_heap[0] = lo_heap[lo_n];
      heap_sift_down(lo_heap, lo_n, 1'b1);
      heap_push(hi_heap, hi_n, y, 1'b0);
    end
    if (lo_n > 0 && hi_n > 0) begin
      y = lo_heap[0];
      z = hi_heap[0];
      if (y > z) begin
        lo_heap[0] = z;
        heap_sift_down(lo_heap, lo_n, 1'b1);
        hi_heap[0] = y;
        heap_sift_down(hi_heap, hi_n, 1'b0);
      end
    end
  endtask

  task automatic predict_median(median_req_t r);
    median_res_t e;
    e.status = 1'b0;
    if (r.req_type == rmth_pkg::REQ_RESTART) begin
      lo_n = 0;
      hi_n = 0;
      heap_push(lo_heap, lo_n, r.value_a ^ rmth_pkg::SIGN_BIT, 1'b1);
    end else if (lo_n + hi_n + 2 > rmth_pkg::CAPACITY) begin
      e.status = 1'b1;
    end else begin
      insert_key(r.value_a ^ rmth_pkg::SIGN_BIT);
      insert_key(r.value_b ^ rmth_pkg::SIGN_BIT);
    end
    e.median = (lo_n > 0) ? (lo_heap[0] ^ rmth_pkg::SIGN_BIT) : 32'sd0;
    expected_medians = {expected_medians, e};
  endtask

  function automatic logic signed [31:0] pick_value(int pool);
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 15)) - 8;
      3: return $signed($urandom_range(0, pool));
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic queue_req(logic t, logic signed [31:0] a, logic signed [31:0] b);
    median_req_t r;
    r.req_type = t;
    r.value_a = a;
    r.value_b = b;
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic drive_next();
    driven_req = pending_reqs[0];
    start       <= 1'b1;
    in_req_type <= driven_req.req_type;
    in_value_a  <= driven_req.value_a;
    in_value_b  <= driven_req.value_b;
  endtask

  // Driver: a word goes when start is high and busy low at the rising edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      start       <= 1'b0;
      in_req_type <= rmth_pkg::REQ_RESTART;
      in_value_a  <= '0;
      in_value_b  <= '0;
    end else if (start && !busy) begin
      // Busy has fallen while start is held, so the word on the ports was taken
      // and its result is due at the next rising edge.
      void'(pending_reqs.pop_front());
      predict_median(driven_req);
      gap_left = (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) ?
                 $urandom_range(1, 10) : 0;
      if (gap_left == 0 && pending_reqs.size() > 0) begin
        drive_next();
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap_left > 0) gap_left--;
      else if (pending_reqs.size() > 0) drive_next();
    end
  end

  // Monitor
  always @(posedge clk) begin
    median_res_t e;
    if (rst_n && out_valid) begin
      if (expected_medians.size() == 0) begin
        $display("%0t: unexpected word, median %0d status %0d", $time, out_median, out_status);
        n_errors++;
      end else begin
        e = expected_medians.pop_front();
        if (out_median !== e.median) begin
          $display("%0t: median expected %0d actual %0d", $time, e.median, out_median);
          n_errors++;
        end
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int k;
    int run_len;
    int pool;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Adds before any restart, then the extremes.
    queue_req(rmth_pkg::REQ_ADD, 32'sd5, -32'sd3);
    queue_req(rmth_pkg::REQ_ADD, 32'sh7fffffff, 32'sh80000000);
    queue_req(rmth_pkg::REQ_RESTART, 32'sh80000000, 32'sd1);
    queue_req(rmth_pkg::REQ_ADD, 32'sh7fffffff, 32'sh7fffffff);
    queue_req(rmth_pkg::REQ_ADD, 32'sh80000000, 32'sh80000000);
    queue_req(rmth_pkg::REQ_RESTART, 32'sh7fffffff, -32'sd1);
    queue_req(rmth_pkg::REQ_ADD, -32'sd1, 32'sd0);
    queue_req(rmth_pkg::REQ_ADD, 32'sd0, 32'sd0);
    queue_req(rmth_pkg::REQ_RESTART, 32'sd0, 32'sh55555555);
    queue_req(rmth_pkg::REQ_ADD, 32'shaaaaaaaa, 32'sh55555555);
    // Fill the store, then overflow it three times.
    queue_req(rmth_pkg::REQ_RESTART, 32'sd7, 32'sd0);
    for (k = 0; k < rmth_pkg::CAPACITY / 2 + 1; k++) begin
      queue_req(rmth_pkg::REQ_ADD, pick_value(1000), pick_value(1000));
    end
    queue_req(rmth_pkg::REQ_ADD, 32'sd1, 32'sd2);

    for (k = 0; k < N_RANDOM;) begin
      run_len = $urandom_range(1, 60);
      pool = $urandom_range(0, 1) ? 100 : 32'h7fffffff;
      queue_req(rmth_pkg::REQ_RESTART, pick_value(pool), $signed($urandom()));
      k++;
      repeat (run_len) begin
        queue_req(rmth_pkg::REQ_ADD, pick_value(pool), pick_value(pool));
        k++;
      end
    end

    wait (pending_reqs.size() == 0 && !start);
    wait (expected_medians.size() == 0);
    repeat (300) @(posedge clk);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
